[rtl/core/artdmx_pkg.sv]
// Shared types and constants for the Art-Net DMX receiver.
`default_nettype none

package artdmx_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NET      = 2'd0,
    CFG_SUBNET   = 2'd1,
    CFG_UNIVERSE = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_TRUNC    = 2'd2,
    KIND_POLL     = 2'd3
  } kind_t;

  localparam logic [15:0] OP_OUTPUT     = 16'h5000;
  localparam logic [15:0] OP_POLL       = 16'h2000;
  localparam logic [15:0] PROTO_VERSION = 16'd14;
  localparam logic [15:0] DATA_START    = 16'd18;
  localparam logic [15:0] POLL_MIN_POS  = 16'd12;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  localparam logic [6:0] NET_RESET      = 7'd0;
  localparam logic [3:0] SUBNET_RESET   = 4'd0;
  localparam logic [3:0] UNIVERSE_RESET = 4'd2;

  // "Art-Net" followed by a zero byte
  localparam logic [7:0] ID_BYTES [8] = '{
    8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00
  };

  typedef struct packed {
    logic [6:0] net;
    logic [3:0] subnet;
    logic [3:0] universe;
  } addr_cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  slot_byte;
    logic [15:0] slot_index;
    logic [7:0]  frame_sequence;
    logic [15:0] frame_length;
    logic        last_result;
  } result_t;

  // Results produced by one decoded byte: zero, one or two
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

`default_nettype wire

[rtl/core/artdmx_ifs.sv]
// Byte input and result output channel interfaces.
`default_nettype none

interface artdmx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_packet;

  modport source (output valid, rx_byte, end_of_packet, input ready);
  modport sink   (input valid, rx_byte, end_of_packet, output ready);
endinterface

interface artdmx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  slot_byte;
  logic [15:0] slot_index;
  logic [7:0]  frame_sequence;
  logic [15:0] frame_length;
  logic        last_result;

  modport source (output valid, kind, slot_byte, slot_index, frame_sequence,
                  frame_length, last_result, input ready);
  modport sink   (input valid, kind, slot_byte, slot_index, frame_sequence,
                  frame_length, last_result, output ready);
endinterface

`default_nettype wire

[rtl/core/artdmx_parse.sv]
// Input register, header field capture and per-byte result generation.
`default_nettype none

module artdmx_parse (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              in_byte,
  input  wire logic                    in_eop,
  input  wire artdmx_pkg::addr_cfg_t   cfg,
  input  wire logic                    room,
  output artdmx_pkg::result_pair_t     results
);

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        held_eop;
  logic        go;

  logic [15:0] byte_position;
  logic        header_valid;
  logic [15:0] opcode_word;
  logic [15:0] protocol_version;
  logic [7:0]  sequence_held;
  logic [7:0]  universe_byte;
  logic [7:0]  net_byte;
  logic [15:0] data_length;

  logic        header_valid_next;
  logic [15:0] opcode_word_next;
  logic [15:0] protocol_version_next;
  logic [7:0]  sequence_held_next;
  logic [7:0]  universe_byte_next;
  logic [7:0]  net_byte_next;
  logic [15:0] data_length_next;

  logic        is_output;
  logic        is_poll;
  logic        data_hit;
  logic        report_hit;
  logic [15:0] data_index;
  logic [15:0] got;
  logic [16:0] need;
  artdmx_pkg::result_t data_res;
  artdmx_pkg::result_t report_res;

  assign go       = held_valid && room;
  assign in_ready = !held_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
      held_eop  <= in_eop;
    end
  end

  // Field capture by byte position
  always_comb begin
    header_valid_next     = header_valid;
    opcode_word_next      = opcode_word;
    protocol_version_next = protocol_version;
    sequence_held_next    = sequence_held;
    universe_byte_next    = universe_byte;
    net_byte_next         = net_byte;
    data_length_next      = data_length;
    if (byte_position[15:3] == 13'd0) begin
      if (held_byte != artdmx_pkg::ID_BYTES[byte_position[2:0]]) begin
        header_valid_next = 1'b0;
      end
    end else begin
      unique case (byte_position)
        16'd8:   opcode_word_next      = {opcode_word[15:8], held_byte};
        16'd9:   opcode_word_next      = {held_byte, opcode_word[7:0]};
        16'd10:  protocol_version_next = {held_byte, protocol_version[7:0]};
        16'd11:  protocol_version_next = {protocol_version[15:8], held_byte};
        16'd12:  sequence_held_next    = held_byte;
        16'd14:  universe_byte_next    = held_byte;
        16'd15:  net_byte_next         = held_byte;
        16'd16:  data_length_next      = {held_byte, data_length[7:0]};
        16'd17:  data_length_next      = {data_length[15:8], held_byte};
        default: ;
      endcase
    end
  end

  always_comb begin
    is_output = header_valid_next
             && (opcode_word_next == artdmx_pkg::OP_OUTPUT)
             && (protocol_version_next == artdmx_pkg::PROTO_VERSION)
             && (net_byte_next == {1'b0, cfg.net})
             && (universe_byte_next == {cfg.subnet, cfg.universe});
    is_poll   = header_valid_next && (opcode_word_next == artdmx_pkg::OP_POLL)
             && (byte_position >= artdmx_pkg::POLL_MIN_POS);

    data_index = byte_position - artdmx_pkg::DATA_START;
    data_hit   = is_output && (byte_position >= artdmx_pkg::DATA_START)
              && (byte_position != artdmx_pkg::POS_MAX)
              && (data_index < data_length_next);

    // Bytes seen so far, saturating
    got  = (byte_position == artdmx_pkg::POS_MAX) ? artdmx_pkg::POS_MAX
                                                  : byte_position + 16'd1;
    need = {1'b0, artdmx_pkg::DATA_START} + {1'b0, data_length_next};

    report_hit = held_eop
              && ((is_output && (byte_position >= artdmx_pkg::DATA_START - 16'd1))
                  || is_poll);

    data_res.kind           = artdmx_pkg::KIND_DATA;
    data_res.slot_byte      = held_byte;
    data_res.slot_index     = data_index;
    data_res.frame_sequence = sequence_held_next;
    data_res.frame_length   = data_length_next;
    data_res.last_result    = !report_hit;

    report_res.slot_byte   = 8'd0;
    report_res.slot_index  = 16'd0;
    report_res.last_result = 1'b1;
    if (is_output && (byte_position >= artdmx_pkg::DATA_START - 16'd1)) begin
      report_res.kind           = (need <= {1'b0, got}) ? artdmx_pkg::KIND_COMPLETE
                                                        : artdmx_pkg::KIND_TRUNC;
      report_res.frame_sequence = sequence_held_next;
      report_res.frame_length   = data_length_next;
    end else begin
      report_res.kind           = artdmx_pkg::KIND_POLL;
      report_res.frame_sequence = 8'd0;
      report_res.frame_length   = 16'd0;
    end

    results.count  = go ? ({1'b0, data_hit} + {1'b0, report_hit}) : 2'd0;
    results.first  = data_hit ? data_res : report_res;
    results.second = report_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 16'd0;
      header_valid     <= 1'b1;
      opcode_word      <= 16'd0;
      protocol_version <= 16'd0;
      sequence_held    <= 8'd0;
      universe_byte    <= 8'd0;
      net_byte         <= 8'd0;
      data_length      <= 16'd0;
    end else if (go) begin
      if (held_eop) begin
        byte_position    <= 16'd0;
        header_valid     <= 1'b1;
        opcode_word      <= 16'd0;
        protocol_version <= 16'd0;
        sequence_held    <= 8'd0;
        universe_byte    <= 8'd0;
        net_byte         <= 8'd0;
        data_length      <= 16'd0;
      end else begin
        if (byte_position != artdmx_pkg::POS_MAX) begin
          byte_position <= byte_position + 16'd1;
        end
        header_valid     <= header_valid_next;
        opcode_word      <= opcode_word_next;
        protocol_version <= protocol_version_next;
        sequence_held    <= sequence_held_next;
        universe_byte    <= universe_byte_next;
        net_byte         <= net_byte_next;
        data_length      <= data_length_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/artdmx_outq.sv]
// Four-entry result queue taking up to two results per cycle.
`default_nettype none

module artdmx_outq (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire artdmx_pkg::result_pair_t results,
  output logic                          room,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output artdmx_pkg::result_t           out_res
);

  artdmx_pkg::result_t entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  // Leave space for the two results a final data byte can cause
  assign room      = (count <= 3'd2);
  assign out_valid = (count != 3'd0);
  assign out_res   = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (results.count != 2'd0) begin
      entries[wr_ptr] <= results.first;
    end
    if (results.count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= results.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + results.count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, results.count} - {2'b00, pop};
    end
  end

endmodule

`default_nettype wire

[rtl/core/artnet_dmx_packet_receiver_core.sv]
// Art-Net receiver top level: address registers, byte decoder and result queue.
//
// Usage: UDP payload bytes enter on in_ch, one beat per byte, with
// end_of_packet set on the last byte of each datagram. Results leave on
// out_ch: a data beat (kind 0) per forwarded DMX slot, then one report
// beat at the packet end (complete, truncated or poll request). Drop all
// data beats of a frame reported as truncated.
// The address registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the channel is idle, as the block
// does not enforce this; index 3 is ignored. A byte taken from in_ch is
// held in the input register, then its results enter the result queue.
// One byte is taken per cycle while the queue has room. A final byte that
// also carries data yields two beats; the four-entry result queue absorbs
// the extra beat. When out_ch stalls, the queue fills and in_ch.ready
// drops once fewer than two entries are free; nothing is lost.
// Reset clears the packet state, empties the queue and loads the default
// address net 0, sub-net 0, universe 2.
`default_nettype none

module artnet_dmx_packet_receiver_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  artdmx_in_if.sink                               in_ch,
  artdmx_out_if.source                            out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [artdmx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [artdmx_pkg::CFG_DATA_W-1:0]  cfg_data
);

  artdmx_pkg::addr_cfg_t    cfg;
  artdmx_pkg::result_pair_t results;
  artdmx_pkg::result_t      out_res;
  logic                     room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.net      <= artdmx_pkg::NET_RESET;
      cfg.subnet   <= artdmx_pkg::SUBNET_RESET;
      cfg.universe <= artdmx_pkg::UNIVERSE_RESET;
    end else if (cfg_we) begin
      unique case (artdmx_pkg::cfg_index_t'(cfg_index))
        artdmx_pkg::CFG_NET:      cfg.net      <= cfg_data;
        artdmx_pkg::CFG_SUBNET:   cfg.subnet   <= cfg_data[3:0];
        artdmx_pkg::CFG_UNIVERSE: cfg.universe <= cfg_data[3:0];
        artdmx_pkg::CFG_UNUSED:   ;
      endcase
    end
  end

  artdmx_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.rx_byte),
    .in_eop   (in_ch.end_of_packet),
    .cfg      (cfg),
    .room     (room),
    .results  (results)
  );

  artdmx_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .results   (results),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.kind           = out_res.kind;
  assign out_ch.slot_byte      = out_res.slot_byte;
  assign out_ch.slot_index     = out_res.slot_index;
  assign out_ch.frame_sequence = out_res.frame_sequence;
  assign out_ch.frame_length   = out_res.frame_length;
  assign out_ch.last_result    = out_res.last_result;

endmodule

`default_nettype wire

[rtl/core/artdmx_checker.sv]
// Port-level checks on the result channel, bound to the top level.
`default_nettype none

module artdmx_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  slot_byte,
  input wire logic [15:0] slot_index,
  input wire logic [7:0]  frame_sequence,
  input wire logic [15:0] frame_length,
  input wire logic        last_result
);

  logic beat;
  assign beat = out_valid && out_ready;

  // A report always closes the results of its byte
  a_report_last: assert property (@(posedge clk) disable iff (rst)
    (beat && (kind != artdmx_pkg::KIND_DATA)) |-> last_result)
    else $error("report beat without last_result");

  a_report_no_slot: assert property (@(posedge clk) disable iff (rst)
    (beat && (kind != artdmx_pkg::KIND_DATA)) |-> (slot_byte == 8'd0 && slot_index == 16'd0))
    else $error("report beat carries slot data");

  a_poll_clean: assert property (@(posedge clk) disable iff (rst)
    (beat && (kind == artdmx_pkg::KIND_POLL))
      |-> (frame_sequence == 8'd0 && frame_length == 16'd0))
    else $error("poll beat carries frame fields");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind artnet_dmx_packet_receiver_core artdmx_checker u_artdmx_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .kind           (out_ch.kind),
  .slot_byte      (out_ch.slot_byte),
  .slot_index     (out_ch.slot_index),
  .frame_sequence (out_ch.frame_sequence),
  .frame_length   (out_ch.frame_length),
  .last_result    (out_ch.last_result)
);

`default_nettype wire
